[design/sled_pkg.sv]
// Shared constants, result type and hex digit helper for the string literal
// escape decoder. No dependencies.
package sled_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Character codes
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_X_LO   = 8'h78;
  localparam logic [7:0] CH_X_UP   = 8'h58;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_F_LO   = 8'h66;
  localparam logic [7:0] CH_A_UP   = 8'h41;
  localparam logic [7:0] CH_F_UP   = 8'h46;

  // Decoded values of the named escapes
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_CR  = 8'd13;

  // A third octal digit on a value at or above this overflows a byte
  localparam logic [7:0] OCT_LIMIT = 8'd32;

  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] kind;
    logic       last;
  } res_t;

  // Value of a hex digit, or HEX_BAD when the byte is not one
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [7:0] t;
    t = 8'd0;
    if (b >= CH_0 && b <= CH_9) begin
      t = b - CH_0;
    end else if (b >= CH_A_LO && b <= CH_F_LO) begin
      t = b - CH_A_LO + 8'd10;
    end else if (b >= CH_A_UP && b <= CH_F_UP) begin
      t = b - CH_A_UP + 8'd10;
    end else begin
      t = {3'd0, HEX_BAD};
    end
    return t[4:0];
  endfunction

endpackage

[design/string_literal_escape_decoder.sv]
// String literal escape decoder: one raw byte in, up to two results out.
// Depends on sled_pkg.
//
//  channel | handshake            | payload
//  --------+----------------------+----------------------------------
//  in      | in_valid_i/in_ready_o  | in_byte_i, end_of_input_i
//  out     | out_valid_o/out_ready_i| out_byte_o, kind_o, last_o
//
// Each item is decoded in the cycle it is accepted; its results sit in a
// three-entry result queue and are registered before they reach the output.
// One item per cycle while items give at most one result each and the output is
// not stalled; an item giving two results slows intake, set by the single output port.
// Input is ready while the queue holds at most one result.
// Reset returns the decoder to the normal phase with an empty queue.
module string_literal_escape_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_input_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic [1:0] kind_o,
  output logic       last_o
);

  typedef enum logic [2:0] {
    PH_NORMAL = 3'd0,
    PH_ESC    = 3'd1,
    PH_HEX1   = 3'd2,
    PH_HEX2   = 3'd3,
    PH_OCT1   = 3'd4,
    PH_OCT2   = 3'd5
  } phase_e;

  localparam int unsigned QDepth = 3;

  phase_e     phase_q, phase_d;
  logic [7:0] accum_q, accum_d;
  logic [1:0] count_q, count_d;
  sled_pkg::res_t q_q [QDepth];
  sled_pkg::res_t q_d [QDepth];

  sled_pkg::res_t res0, res1, rn;
  logic [1:0] n_res;
  logic       norm_en;
  logic [4:0] hd;
  logic       is_oct;
  logic       push, pop;
  logic [1:0] base;

  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;

  assign is_oct = (in_byte_i >= sled_pkg::CH_0) && (in_byte_i <= sled_pkg::CH_7);
  assign hd     = sled_pkg::hex_digit(in_byte_i);

  // Decode one item: next phase, accumulator and up to two results
  always_comb begin
    phase_d = phase_q;
    accum_d = accum_q;
    res0    = '{data: 8'd0, kind: sled_pkg::KIND_ERROR, last: 1'b1};
    res1    = '{data: 8'd0, kind: sled_pkg::KIND_ERROR, last: 1'b1};
    rn      = '{data: 8'd0, kind: sled_pkg::KIND_ERROR, last: 1'b1};
    n_res   = 2'd0;
    norm_en = 1'b0;
    if (end_of_input_i) begin
      phase_d = PH_NORMAL;
      accum_d = 8'd0;
      n_res   = 2'd1;
    end else begin
      unique case (phase_q)
        PH_NORMAL: norm_en = 1'b1;
        PH_ESC: begin
          phase_d = PH_NORMAL;
          if (is_oct) begin
            accum_d = in_byte_i - sled_pkg::CH_0;
            phase_d = PH_OCT1;
          end else if (in_byte_i == sled_pkg::CH_X_LO || in_byte_i == sled_pkg::CH_X_UP) begin
            accum_d = 8'd0;
            phase_d = PH_HEX1;
          end else begin
            n_res     = 2'd1;
            res0.kind = sled_pkg::KIND_BYTE;
            priority if (in_byte_i == sled_pkg::CH_N) res0.data = sled_pkg::CODE_LF;
            else if (in_byte_i == sled_pkg::CH_T) res0.data = sled_pkg::CODE_TAB;
            else if (in_byte_i == sled_pkg::CH_R) res0.data = sled_pkg::CODE_CR;
            else res0.data = in_byte_i;
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (hd == sled_pkg::HEX_BAD) begin
            phase_d = PH_NORMAL;
            accum_d = 8'd0;
            n_res   = 2'd1;
          end else if (phase_q == PH_HEX1) begin
            accum_d = {4'd0, hd[3:0]};
            phase_d = PH_HEX2;
          end else begin
            n_res     = 2'd1;
            res0.kind = sled_pkg::KIND_BYTE;
            res0.data = {accum_q[3:0], hd[3:0]};
            accum_d   = 8'd0;
            phase_d   = PH_NORMAL;
          end
        end
        PH_OCT1, PH_OCT2: begin
          if (!is_oct) begin
            // Flush the pending value, then treat the byte as plain text
            n_res     = 2'd1;
            res0.kind = sled_pkg::KIND_BYTE;
            res0.data = accum_q;
            accum_d   = 8'd0;
            phase_d   = PH_NORMAL;
            norm_en   = 1'b1;
          end else if (phase_q == PH_OCT2 && accum_q >= sled_pkg::OCT_LIMIT) begin
            phase_d = PH_NORMAL;
            accum_d = 8'd0;
            n_res   = 2'd1;
          end else if (phase_q == PH_OCT1) begin
            accum_d = {accum_q[4:0], in_byte_i[2:0]};
            phase_d = PH_OCT2;
          end else begin
            n_res     = 2'd1;
            res0.kind = sled_pkg::KIND_BYTE;
            res0.data = {accum_q[4:0], in_byte_i[2:0]};
            accum_d   = 8'd0;
            phase_d   = PH_NORMAL;
          end
        end
        default: begin
          phase_d = PH_NORMAL;
          accum_d = 8'd0;
          n_res   = 2'd1;
        end
      endcase

      if (norm_en) begin
        if (in_byte_i == sled_pkg::CH_BSLASH) begin
          phase_d = PH_ESC;
        end else begin
          if (in_byte_i == sled_pkg::CH_QUOTE) begin
            rn.kind = sled_pkg::KIND_END;
          end else begin
            rn.kind = sled_pkg::KIND_BYTE;
            rn.data = in_byte_i;
          end
          if (n_res == 2'd0) begin
            res0 = rn;
          end else begin
            res1 = rn;
          end
          n_res = n_res + 2'd1;
        end
      end
    end
    // Only the final result of an item carries last
    res0.last = (n_res == 2'd1);
    res1.last = 1'b1;
  end

  // Result queue: head in slot zero, shift on pop, append on push
  always_comb begin
    for (int i = 0; i < QDepth; i++) begin
      q_d[i] = q_q[i];
    end
    base = count_q;
    if (pop) begin
      for (int i = 0; i < QDepth - 1; i++) begin
        q_d[i] = q_q[i + 1];
      end
      base = count_q - 2'd1;
    end
    count_d = base;
    if (push) begin
      for (int i = 0; i < QDepth; i++) begin
        if (n_res != 2'd0 && base == 2'(i)) q_d[i] = res0;
        if (n_res == 2'd2 && base + 2'd1 == 2'(i)) q_d[i] = res1;
      end
      count_d = base + n_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_NORMAL;
      accum_q <= 8'd0;
      count_q <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        phase_q <= phase_d;
        accum_q <= accum_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < QDepth; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  assign in_ready_o  = (count_q <= 2'd1);
  assign out_valid_o = (count_q != 2'd0);
  assign out_byte_o  = q_q[0].data;
  assign kind_o      = q_q[0].kind;
  assign last_o      = q_q[0].last;

  // End of input always leaves a clean normal phase
  a_eoi_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && end_of_input_i |=> phase_q == PH_NORMAL && accum_q == 8'd0)
    else $error("end of input left escape state behind");

  // A lone queued result closes its item
  a_tail_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == 2'd1 |-> last_o)
    else $error("lone queued result lacks last");

  // Only decoded bytes carry data
  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != sled_pkg::KIND_BYTE |-> out_byte_o == 8'd0)
    else $error("non-byte result carries data");

  // Queue never overruns
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push && n_res == 2'd2 |-> count_q <= 2'd1)
    else $error("result queue overrun");

  // A popped result with last clear is followed by its partner
  a_pair_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && !last_o |=> out_valid_o)
    else $error("second result of an item went missing");

endmodule
